// ----- design/dtfs_pkg.sv -----
// ----------------------------------------------------------------------------
// dtfs_pkg: shared types and constants of the dirty-tracked field store
// Command and result codes, controller states and the control/status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dtfs_pkg;

    localparam int FIELD_SLOTS_DEF = 64;

    localparam int CMD_W  = 3;
    localparam int IDX_W  = 6;
    localparam int LANE_W = 3;
    localparam int DATA_W = 64;
    localparam int WORD_W = 32;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int CNT_W  = 7;

    // highest byte lane inside a field
    localparam int MAX_LANE = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_WORD   = 3'd0,
        CMD_WR_DOUBLE = 3'd1,
        CMD_WR_BYTE   = 3'd2,
        CMD_RD_DOUBLE = 3'd3,
        CMD_FLUSH     = 3'd4,
        CMD_DUMP      = 3'd5
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ    = 2'd0,
        KIND_CHANGED = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_DUMP    = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR_WORD,
        ST_WR_DLO,
        ST_WR_DHI,
        ST_WR_BYTE,
        ST_RD,
        ST_SCAN,
        ST_TAIL,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic wr_lo;
        logic wr_hi;
        logic wr_byte;
        logic rd_emit;
        logic scan_run;
        logic scan_tail;
        logic fin_emit;
    } dp_ctl_t;

    typedef struct packed {
        logic scan_last;
    } dp_sts_t;

endpackage

// ----- design/dtfs_dp.sv -----
// ----------------------------------------------------------------------------
// dtfs_dp: datapath of the dirty-tracked field store
// Field memory with per-entry valid bits, change bits, scan pipeline and
// the registered result port.
// ----------------------------------------------------------------------------
module dtfs_dp #(
    parameter int FIELD_SLOTS = dtfs_pkg::FIELD_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dtfs_pkg::dp_ctl_t             ctl,
    output dtfs_pkg::dp_sts_t             sts,
    input  logic                          cfg_we,
    input  logic [dtfs_pkg::CNT_W-1:0]    active_field_count,
    input  logic [dtfs_pkg::CMD_W-1:0]    command,
    input  logic [dtfs_pkg::IDX_W-1:0]    field_index,
    input  logic [dtfs_pkg::LANE_W-1:0]   byte_offset,
    input  logic [dtfs_pkg::DATA_W-1:0]   write_value,
    output logic                          result_strobe,
    output logic [dtfs_pkg::KIND_W-1:0]   result_kind,
    output logic [dtfs_pkg::IDX_W-1:0]    out_index,
    output logic [dtfs_pkg::DATA_W-1:0]   out_value,
    output logic [dtfs_pkg::CNT_W-1:0]    out_count,
    output logic                          last
);
    import dtfs_pkg::*;

    localparam int AW = $clog2(FIELD_SLOTS);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(FIELD_SLOTS);

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (v > SLOTS_C)
        begin
            r = SLOTS_C;
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] safe_addr(input logic [CNT_W-1:0] v);
        logic [AW-1:0] r;
        r = '0;
        if (v < SLOTS_C)
        begin
            r = v[AW-1:0];
        end
        return r;
    endfunction

    // configuration and latched command
    logic [CNT_W-1:0]  n_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [LANE_W-1:0] lane_reg;
    logic [DATA_W-1:0] data_reg;

    // memory
    logic [WORD_W-1:0]      mem [FIELD_SLOTS];
    logic [FIELD_SLOTS-1:0] vld_reg;
    logic [FIELD_SLOTS-1:0] chg_reg;
    logic [WORD_W-1:0]      rd_a_reg;
    logic [WORD_W-1:0]      rd_b_reg;

    // scan pipeline
    logic [AW-1:0]     ptr_reg;
    logic              s1_vld_reg;
    logic [AW-1:0]     s1_idx_reg;
    logic              pend_vld_reg;
    logic [AW-1:0]     pend_idx_reg;
    logic [WORD_W-1:0] pend_val_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // result registers
    logic              strobe_reg, strobe_next;
    kind_t             kind_reg, kind_next;
    logic [IDX_W-1:0]  oidx_reg, oidx_next;
    logic [DATA_W-1:0] oval_reg, oval_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic              olast_reg, olast_next;

    logic [CNT_W-1:0]  idx_ext, idx_nx, port_a, port_b;
    logic              lo_ok, hi_ok, is_dump, sel, stage1;
    logic              rd_en;
    logic [AW-1:0]     ra, rb;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [4:0]        byte_base;
    logic [WORD_W-1:0] byte_word;

    assign idx_ext = CNT_W'(idx_reg);
    assign idx_nx  = idx_ext + CNT_W'(1);
    assign lo_ok   = idx_ext < n_reg;
    assign hi_ok   = idx_nx < n_reg;
    assign port_a  = CNT_W'(field_index);
    assign port_b  = port_a + CNT_W'(1);
    assign is_dump = (cmd_reg == CMD_DUMP);
    assign sel     = is_dump || chg_reg[ptr_reg];
    assign stage1  = ctl.scan_run || ctl.scan_tail;

    assign rd_en = ctl.accept || ctl.scan_run;
    assign ra    = ctl.accept ? safe_addr(port_a) : ptr_reg;
    assign rb    = safe_addr(port_b);

    assign sts.scan_last = (CNT_W'(ptr_reg) == (n_reg - CNT_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= SLOTS_C;
        end
        else if (cfg_we)
        begin
            n_reg <= clamp_count(active_field_count);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= command;
            idx_reg  <= field_index;
            lane_reg <= byte_offset;
            data_reg <= write_value;
        end
    end

    // write only where the stored value really changes
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = idx_reg[AW-1:0];
        wr_data   = data_reg[WORD_W-1:0];
        byte_base = {lane_reg[1:0], 3'b000};
        byte_word = rd_a_reg;
        byte_word[byte_base +: BYTE_W] = data_reg[BYTE_W-1:0];
        if (ctl.wr_lo && lo_ok && (rd_a_reg != data_reg[WORD_W-1:0]))
        begin
            wr_en = 1'b1;
        end
        if (ctl.wr_hi && hi_ok && (rd_b_reg != data_reg[DATA_W-1:WORD_W]))
        begin
            wr_en   = 1'b1;
            wr_addr = idx_nx[AW-1:0];
            wr_data = data_reg[DATA_W-1:WORD_W];
        end
        if (ctl.wr_byte && lo_ok && (lane_reg <= LANE_W'(MAX_LANE))
            && (rd_a_reg[byte_base +: BYTE_W] != data_reg[BYTE_W-1:0]))
        begin
            wr_en   = 1'b1;
            wr_data = byte_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= vld_reg[ra] ? mem[ra] : '0;
            rd_b_reg <= vld_reg[rb] ? mem[rb] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            chg_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
                chg_reg[wr_addr] <= 1'b1;
            end
            if (ctl.scan_run && !is_dump)
            begin
                chg_reg[ptr_reg] <= 1'b0;
            end
        end
    end

    // scan: stage 0 reads at the pointer, stage 1 marks a selected entry, pend holds one entry back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            s1_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (ctl.accept)
        begin
            ptr_reg      <= '0;
            s1_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (ctl.scan_run)
            begin
                ptr_reg    <= ptr_reg + AW'(1);
                s1_vld_reg <= sel;
            end
            else if (ctl.scan_tail)
            begin
                s1_vld_reg <= 1'b0;
            end
            if (stage1 && s1_vld_reg)
            begin
                cnt_reg      <= cnt_reg + CNT_W'(1);
                pend_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.scan_run)
        begin
            s1_idx_reg <= ptr_reg;
        end
        if (stage1 && s1_vld_reg)
        begin
            pend_idx_reg <= s1_idx_reg;
            pend_val_reg <= rd_a_reg;
        end
    end

    always_comb
    begin
        strobe_next = 1'b0;
        kind_next   = kind_reg;
        oidx_next   = oidx_reg;
        oval_next   = oval_reg;
        ocnt_next   = ocnt_reg;
        olast_next  = olast_reg;
        if (ctl.rd_emit)
        begin
            strobe_next = 1'b1;
            kind_next   = KIND_READ;
            oidx_next   = idx_reg;
            oval_next   = {(hi_ok ? rd_b_reg : {WORD_W{1'b0}}),
                           (lo_ok ? rd_a_reg : {WORD_W{1'b0}})};
            ocnt_next   = CNT_W'(1);
            olast_next  = 1'b1;
        end
        else if (stage1 && s1_vld_reg && pend_vld_reg)
        begin
            strobe_next = 1'b1;
            kind_next   = is_dump ? KIND_DUMP : KIND_CHANGED;
            oidx_next   = IDX_W'(pend_idx_reg);
            oval_next   = {{WORD_W{1'b0}}, pend_val_reg};
            ocnt_next   = '0;
            olast_next  = 1'b0;
        end
        else if (ctl.fin_emit)
        begin
            strobe_next = 1'b1;
            olast_next  = 1'b1;
            if (pend_vld_reg)
            begin
                kind_next = is_dump ? KIND_DUMP : KIND_CHANGED;
                oidx_next = IDX_W'(pend_idx_reg);
                oval_next = {{WORD_W{1'b0}}, pend_val_reg};
                ocnt_next = cnt_reg;
            end
            else
            begin
                kind_next = KIND_EMPTY;
                oidx_next = '0;
                oval_next = '0;
                ocnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        oidx_reg  <= oidx_next;
        oval_reg  <= oval_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    assign result_strobe = strobe_reg;
    assign result_kind   = kind_reg;
    assign out_index     = oidx_reg;
    assign out_value     = oval_reg;
    assign out_count     = ocnt_reg;
    assign last          = olast_reg;

endmodule

// ----- design/dtfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtfs_ctrl: controller of the dirty-tracked field store
// Sequences each command through the datapath and drives busy.
// ----------------------------------------------------------------------------
module dtfs_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dtfs_pkg::CMD_W-1:0] command,
    input  dtfs_pkg::dp_sts_t          sts,
    output dtfs_pkg::dp_ctl_t          ctl,
    output logic                       busy
);
    import dtfs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.accept = 1'b1;
                    case (command)
                        CMD_WR_WORD:   state_next = ST_WR_WORD;
                        CMD_WR_DOUBLE: state_next = ST_WR_DLO;
                        CMD_WR_BYTE:   state_next = ST_WR_BYTE;
                        CMD_RD_DOUBLE: state_next = ST_RD;
                        CMD_FLUSH:     state_next = ST_SCAN;
                        CMD_DUMP:      state_next = ST_SCAN;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WR_WORD:
            begin
                ctl.wr_lo  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WR_DLO:
            begin
                ctl.wr_lo  = 1'b1;
                state_next = ST_WR_DHI;
            end
            ST_WR_DHI:
            begin
                ctl.wr_hi  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WR_BYTE:
            begin
                ctl.wr_byte = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_RD:
            begin
                ctl.rd_emit = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_SCAN:
            begin
                ctl.scan_run = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                ctl.scan_tail = 1'b1;
                state_next    = ST_FIN;
            end
            ST_FIN:
            begin
                ctl.fin_emit = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/dirty_tracked_field_store_unit.sv -----
// ----------------------------------------------------------------------------
// dirty_tracked_field_store_unit: 32-bit field store with change tracking
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low; command, field_index, byte_offset and write_value travel
//   with it. Busy spans the write state of a word or byte write,
//   both half states of a double write and the read state of a double read.
//   Flush and dump walk the active fields one per cycle through the field
//   memory's read port; busy stays high through that walk and then a tail
//   state and a final state; the walk covers the effective active field count.
//   Results: each result sits on the result ports for exactly one cycle with
//   result_strobe high; the receiver cannot stall, so nothing is held back.
//   A read result shows in the first cycle with busy low; scan results
//   are held back by one selected entry so that the final one, which carries
//   out_count, is known; that final one shows in the first cycle with busy low.
//   Configuration: active_field_count is written with cfg_valid; cfg_ready
//   is always high. Write it only while the block is idle.
//   Reset: all fields read as zero, change bits clear, the active count is
//   the full store; the block is ready on the first edge after reset.
// ----------------------------------------------------------------------------
module dirty_tracked_field_store_unit #(
    parameter int FIELD_SLOTS = dtfs_pkg::FIELD_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dtfs_pkg::CMD_W-1:0]    command,
    input  logic [dtfs_pkg::IDX_W-1:0]    field_index,
    input  logic [dtfs_pkg::LANE_W-1:0]   byte_offset,
    input  logic [dtfs_pkg::DATA_W-1:0]   write_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dtfs_pkg::CNT_W-1:0]    active_field_count,
    output logic                          result_strobe,
    output logic [dtfs_pkg::KIND_W-1:0]   result_kind,
    output logic [dtfs_pkg::IDX_W-1:0]    out_index,
    output logic [dtfs_pkg::DATA_W-1:0]   out_value,
    output logic [dtfs_pkg::CNT_W-1:0]    out_count,
    output logic                          last
);
    import dtfs_pkg::*;

    dp_ctl_t ctl;
    dp_sts_t sts;
    logic    cfg_we;

    // the count register takes a write on any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    dtfs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .sts     (sts),
        .ctl     (ctl),
        .busy    (busy)
    );

    dtfs_dp #(
        .FIELD_SLOTS (FIELD_SLOTS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .sts                (sts),
        .cfg_we             (cfg_we),
        .active_field_count (active_field_count),
        .command            (command),
        .field_index        (field_index),
        .byte_offset        (byte_offset),
        .write_value        (write_value),
        .result_strobe      (result_strobe),
        .result_kind        (result_kind),
        .out_index          (out_index),
        .out_value          (out_value),
        .out_count          (out_count),
        .last               (last)
    );

endmodule

// ----- design/dtfs_chk.sv -----
// ----------------------------------------------------------------------------
// dtfs_chk: port-level checks for the dirty-tracked field store
// Watches the command and result ports of the top level over time.
// ----------------------------------------------------------------------------
module dtfs_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [dtfs_pkg::CMD_W-1:0]    command,
    input logic                          result_strobe,
    input logic [dtfs_pkg::KIND_W-1:0]   result_kind,
    input logic [dtfs_pkg::DATA_W-1:0]   out_value,
    input logic [dtfs_pkg::CNT_W-1:0]    out_count,
    input logic                          last
);
    import dtfs_pkg::*;

    // a result only follows a cycle of work
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result without preceding busy cycle");

    // count shows only on the final result of a run
    a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |-> (out_count == '0))
        else $error("count on a non-final result");

    a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (result_kind == KIND_READ)) |-> (last && out_count == CNT_W'(1)))
        else $error("read result malformed");

    a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (result_kind == KIND_EMPTY))
            |-> (last && out_count == '0 && out_value == '0))
        else $error("empty flush result malformed");

    // a scan transaction always occupies the block
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_FLUSH || command == CMD_DUMP)) |=> busy)
        else $error("scan taken without going busy");

endmodule

bind dirty_tracked_field_store_unit dtfs_chk u_dtfs_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .result_strobe (result_strobe),
    .result_kind   (result_kind),
    .out_value     (out_value),
    .out_count     (out_count),
    .last          (last)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for dirty_tracked_field_store_unit
// Drives word, double, byte, read, flush and dump commands through the start
// and busy handshake, keeps a shadow copy of the field store and its change
// bits, and compares every strobed result field by field with the oldest
// predicted entry. Runs directed cases, an active field count sweep and
// three randomised phases with different sender gap rates.
// ----------------------------------------------------------------------------
module tb;
    import dtfs_pkg::*;

    localparam int FIELD_SLOTS    = FIELD_SLOTS_DEF;
    localparam int QUIET_LIMIT    = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WRITE_SETTLE   = 4;

    // one predicted result entry, laid out like the result ports
    typedef struct {
        kind_t              kind;
        logic [IDX_W-1:0]   index;
        logic [DATA_W-1:0]  value;
        logic [CNT_W-1:0]   count;
        logic               last;
    } field_result_t;

    logic               clk;
    logic               rst_n              = 1'b0;
    logic               start              = 1'b0;
    logic               busy;
    logic [CMD_W-1:0]   command            = '0;
    logic [IDX_W-1:0]   field_index        = '0;
    logic [LANE_W-1:0]  byte_offset        = '0;
    logic [DATA_W-1:0]  write_value        = '0;
    logic               cfg_valid          = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   active_field_count = 7'd64;
    logic               result_strobe;
    logic [KIND_W-1:0]  result_kind;
    logic [IDX_W-1:0]   out_index;
    logic [DATA_W-1:0]  out_value;
    logic [CNT_W-1:0]   out_count;
    logic               last;

    // shadow of the block: field contents, change bits and the count register
    logic [WORD_W-1:0]  shadow_fields [FIELD_SLOTS];
    bit                 shadow_changed [FIELD_SLOTS];
    logic [CNT_W-1:0]   shadow_count;

    field_result_t      awaited_results [$];
    int                 mismatches  = 0;
    int                 quiet_cycles = 0;
    int                 gap_pct     = 0;

    dirty_tracked_field_store_unit #(
        .FIELD_SLOTS (FIELD_SLOTS)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .command            (command),
        .field_index        (field_index),
        .byte_offset        (byte_offset),
        .write_value        (write_value),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .active_field_count (active_field_count),
        .result_strobe      (result_strobe),
        .result_kind        (result_kind),
        .out_index          (out_index),
        .out_value          (out_value),
        .out_count          (out_count),
        .last               (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow store
    // ------------------------------------------------------------------

    // Clamp the written count to 1..FIELD_SLOTS, as the block does.
    function automatic int live_fields();
        int n;
        n = shadow_count;
        if (n < 1)
            n = 1;
        if (n > FIELD_SLOTS)
            n = FIELD_SLOTS;
        return n;
    endfunction

    // Store a word and raise its change bit only if the value really moves.
    function automatic void shadow_put_word(input int idx, input logic [WORD_W-1:0] value);
        if (idx >= live_fields())
            return;
        if (shadow_fields[idx] == value)
            return;
        shadow_fields[idx]  = value;
        shadow_changed[idx] = 1'b1;
    endfunction

    // Out-of-range halves of a read come back as zero.
    function automatic logic [WORD_W-1:0] shadow_get_word(input int idx);
        if (idx >= live_fields())
            return '0;
        return shadow_fields[idx];
    endfunction

    function automatic void await_result(input kind_t kind, input int index,
                                         input logic [DATA_W-1:0] value,
                                         input int count, input logic is_last);
        field_result_t r;
        r.kind  = kind;
        r.index = index[IDX_W-1:0];
        r.value = value;
        r.count = count[CNT_W-1:0];
        r.last  = is_last;
        awaited_results.push_back(r);
    endfunction

    // Advance the shadow by one accepted transaction and queue the results
    // that it produces.
    function automatic void advance_field_store(input logic [CMD_W-1:0] cmd,
                                                input logic [IDX_W-1:0] idx_in,
                                                input logic [LANE_W-1:0] lane,
                                                input logic [DATA_W-1:0] data);
        int n;
        int idx;
        int sh;
        int total;
        int emitted;
        n   = live_fields();
        idx = idx_in;
        case (cmd)
            CMD_WR_WORD:
                shadow_put_word(idx, data[31:0]);
            CMD_WR_DOUBLE:
            begin
                // each half is range checked on its own
                shadow_put_word(idx, data[31:0]);
                shadow_put_word(idx + 1, data[63:32]);
            end
            CMD_WR_BYTE:
            begin
                if (lane <= MAX_LANE && idx < n)
                begin
                    sh = lane * BYTE_W;
                    if (shadow_fields[idx][sh +: BYTE_W] != data[7:0])
                    begin
                        shadow_fields[idx][sh +: BYTE_W] = data[7:0];
                        shadow_changed[idx] = 1'b1;
                    end
                end
            end
            CMD_RD_DOUBLE:
                await_result(KIND_READ, idx,
                             {shadow_get_word(idx + 1), shadow_get_word(idx)}, 1, 1'b1);
            CMD_FLUSH:
            begin
                total = 0;
                for (int i = 0; i < n; i++)
                    if (shadow_changed[i])
                        total++;
                if (total == 0)
                    await_result(KIND_EMPTY, 0, '0, 0, 1'b1);
                else
                begin
                    emitted = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (shadow_changed[i])
                        begin
                            shadow_changed[i] = 1'b0;
                            emitted++;
                            await_result(KIND_CHANGED, i, {32'd0, shadow_fields[i]},
                                         (emitted == total) ? total : 0,
                                         emitted == total);
                        end
                    end
                end
            end
            CMD_DUMP:
                for (int i = 0; i < n; i++)
                    await_result(KIND_DUMP, i, {32'd0, shadow_fields[i]},
                                 (i + 1 == n) ? n : 0, i + 1 == n);
            default:
                ; // unused command codes are dropped
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest awaited entry
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        field_result_t want;
        if (rst_n && result_strobe)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: kind %0d index %0d value %h count %0d last %0b",
                             $realtime, result_kind, out_index, out_value, out_count, last);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result_kind !== want.kind || out_index !== want.index ||
                    out_value !== want.value || out_count !== want.count ||
                    last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("[%0t] result mismatch", $realtime);
                        $display("    expected kind %0d index %0d value %h count %0d last %0b",
                                 want.kind, want.index, want.value, want.count, want.last);
                        $display("    actual   kind %0d index %0d value %h count %0d last %0b",
                                 result_kind, out_index, out_value, out_count, last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any accepted transaction, result or register write counts
    // as progress; a long quiet stretch ends the run.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present one command and hold it until the block takes it. Start is
    // left high on acceptance so that back-to-back commands need no gap;
    // a following gap or park_command_bus lowers it.
    task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                                 input logic [LANE_W-1:0] lane,
                                 input logic [DATA_W-1:0] data);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        field_index <= idx;
        byte_offset <= lane;
        write_value <= data;
        do
            @(posedge clk);
        while (busy);
        advance_field_store(cmd, idx, lane, data);
    endtask

    // Drop start and step past the edge so a later raise never shares a step.
    task automatic park_command_bus();
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_results_drained();
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Rewrite the active field count with the block idle: drain results,
    // let any trailing write finish, then complete one register transaction.
    task automatic write_field_count(input logic [CNT_W-1:0] value);
        park_command_bus();
        wait_results_drained();
        repeat (WRITE_SETTLE) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_valid          <= 1'b1;
        active_field_count <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        shadow_count  = value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic apply_reset();
        for (int i = 0; i < FIELD_SLOTS; i++)
        begin
            shadow_fields[i]  = '0;
            shadow_changed[i] = 1'b0;
        end
        shadow_count = 7'd64;
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    endtask

    // Store must read back all zero and clean straight after reset.
    task automatic test_reset_contents();
        gap_pct = 0;
        issue_command(CMD_DUMP, 6'd0, 3'd0, '0);
        issue_command(CMD_FLUSH, 6'd0, 3'd0, '0);
        issue_command(CMD_RD_DOUBLE, 6'd63, 3'd0, '0);
    endtask

    // Writes of each kind, the no-change cases, lanes and the top boundary.
    task automatic test_write_paths();
        gap_pct = 10;
        // same value as stored: no change bit
        issue_command(CMD_WR_WORD, 6'd0, 3'd0, 64'hFFFF_FFFF_0000_0000);
        issue_command(CMD_WR_WORD, 6'd63, 3'd7, 64'h0000_0000_FFFF_FFFF);
        issue_command(CMD_WR_DOUBLE, 6'd10, 3'd0, 64'hA5A5_A5A5_5A5A_5A5A);
        // top of the store: upper half falls off the end
        issue_command(CMD_WR_DOUBLE, 6'd63, 3'd0, 64'h1234_5678_8765_4321);
        issue_command(CMD_WR_BYTE, 6'd5, 3'd0, 64'hFFFF_FFFF_FFFF_FF11);
        issue_command(CMD_WR_BYTE, 6'd5, 3'd1, 64'h0000_0000_0000_0022);
        issue_command(CMD_WR_BYTE, 6'd5, 3'd2, 64'h0000_0000_0000_0033);
        issue_command(CMD_WR_BYTE, 6'd5, 3'd3, 64'hFFFF_FFFF_FFFF_FF80);
        // lane above 3 is ignored
        issue_command(CMD_WR_BYTE, 6'd6, 3'd7, 64'h0000_0000_0000_00FF);
        issue_command(CMD_WR_BYTE, 6'd6, 3'd4, 64'h0000_0000_0000_0001);
        // rewriting the stored byte leaves the field clean
        issue_command(CMD_WR_BYTE, 6'd7, 3'd2, 64'hFFFF_FFFF_FFFF_FF00);
    endtask

    // Reads around the boundary, flush with and without changes, unused codes, dump.
    task automatic test_read_flush_dump();
        gap_pct = 10;
        issue_command(CMD_RD_DOUBLE, 6'd62, 3'd0, '0);
        issue_command(CMD_RD_DOUBLE, 6'd10, 3'd0, '1);
        issue_command(CMD_RD_DOUBLE, 6'd5, 3'd0, '0);
        issue_command(CMD_FLUSH, 6'd0, 3'd0, '0);
        issue_command(CMD_FLUSH, 6'd63, 3'd7, '1);
        issue_command(3'd6, 6'd1, 3'd0, '1);
        issue_command(3'd7, 6'd2, 3'd0, '1);
        issue_command(CMD_DUMP, 6'd0, 3'd0, '0);
    endtask

    // Walk the count register through its extremes, including zero and
    // values beyond the store, with boundary traffic under each setting.
    task automatic test_count_extremes();
        logic [CNT_W-1:0] settings [6];
        int n;
        settings = '{7'd0, 7'd127, 7'd1, 7'd2, 7'd65, 7'd64};
        gap_pct = 10;
        foreach (settings[s])
        begin
            write_field_count(settings[s]);
            n = live_fields();
            issue_command(CMD_WR_DOUBLE, 6'(n - 1), 3'd0, {$urandom, $urandom});
            issue_command(CMD_RD_DOUBLE, 6'(n - 1), 3'd0, '0);
            issue_command(CMD_FLUSH, 6'd0, 3'd0, '0);
            issue_command(CMD_DUMP, 6'd0, 3'd0, '0);
        end
    endtask

    // Weighted random mix; most writes land in or just past the active range
    // and some reuse the stored value so the no-change path stays busy.
    task automatic test_random_traffic(input int items, input int pct);
        int               counted;
        int               n;
        int               pick;
        int               idx;
        logic [CMD_W-1:0] cmd;
        logic [LANE_W-1:0] lane;
        logic [DATA_W-1:0] data;
        counted = 0;
        gap_pct = pct;
        while (counted < items)
        begin
            n    = live_fields();
            pick = $urandom_range(0, 99);
            if (pick < 25)
                cmd = CMD_WR_WORD;
            else if (pick < 40)
                cmd = CMD_WR_DOUBLE;
            else if (pick < 60)
                cmd = CMD_WR_BYTE;
            else if (pick < 80)
                cmd = CMD_RD_DOUBLE;
            else if (pick < 90)
                cmd = CMD_FLUSH;
            else if (pick < 95)
                cmd = CMD_DUMP;
            else
                cmd = 3'($urandom_range(6, 7));
            if ($urandom_range(0, 9) < 7)
                idx = $urandom_range(0, (n > 63) ? 63 : n);
            else
                idx = $urandom_range(0, 63);
            if ($urandom_range(0, 9) == 0)
                lane = 3'($urandom_range(4, 7));
            else
                lane = 3'($urandom_range(0, 3));
            data = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0: data = '0;
                1: data = '1;
                2, 3:
                begin
                    if (cmd == CMD_WR_BYTE)
                        data[7:0] = shadow_fields[idx][lane[1:0] * BYTE_W +: BYTE_W];
                    else
                    begin
                        data[31:0] = shadow_fields[idx];
                        if (idx < 63)
                            data[63:32] = shadow_fields[idx + 1];
                    end
                end
                default: ;
            endcase
            issue_command(cmd, idx[IDX_W-1:0], lane, data);
            counted++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        apply_reset();
        test_reset_contents();
        test_write_paths();
        test_read_flush_dump();
        test_count_extremes();

        // sender gaps light, then heavy, then none
        write_field_count(7'($urandom_range(1, 64)));
        test_random_traffic(135, 10);
        write_field_count(7'($urandom_range(1, 16)));
        test_random_traffic(135, 78);
        write_field_count(7'd64);
        test_random_traffic(135, 0);

        park_command_bus();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
